// ----- rtl/core/gn2d_pkg.sv -----
// Shared constants, permutation ROM and gradient select codes for the noise pipeline.
package gn2d_pkg;

  localparam int COORD_W = 24;
  localparam int CELL_W  = 8;
  localparam int OUT_W   = 19;

  localparam int OUT_MAX = 262143;
  localparam int OUT_MIN = -262144;

  // gradient select: u is y from this code up, v is y below GRAD_V_Y_BELOW,
  // v is x for the two extra codes, else zero
  localparam logic [3:0] GRAD_U_Y_FROM  = 4'd8;
  localparam logic [3:0] GRAD_V_Y_BELOW = 4'd4;
  localparam logic [3:0] GRAD_V_X_A     = 4'd12;
  localparam logic [3:0] GRAD_V_X_B     = 4'd14;

  localparam logic [7:0] PERM_ROM [256] = '{
    8'd151, 8'd160, 8'd137, 8'd91,  8'd90,  8'd15,  8'd131, 8'd13,
    8'd201, 8'd95,  8'd96,  8'd53,  8'd194, 8'd233, 8'd7,   8'd225,
    8'd140, 8'd36,  8'd103, 8'd30,  8'd69,  8'd142, 8'd8,   8'd99,
    8'd37,  8'd240, 8'd21,  8'd10,  8'd23,  8'd190, 8'd6,   8'd148,
    8'd247, 8'd120, 8'd234, 8'd75,  8'd0,   8'd26,  8'd197, 8'd62,
    8'd94,  8'd252, 8'd219, 8'd203, 8'd117, 8'd35,  8'd11,  8'd32,
    8'd57,  8'd177, 8'd33,  8'd88,  8'd237, 8'd149, 8'd56,  8'd87,
    8'd174, 8'd20,  8'd125, 8'd136, 8'd171, 8'd168, 8'd68,  8'd175,
    8'd74,  8'd165, 8'd71,  8'd134, 8'd139, 8'd48,  8'd27,  8'd166,
    8'd77,  8'd146, 8'd158, 8'd231, 8'd83,  8'd111, 8'd229, 8'd122,
    8'd60,  8'd211, 8'd133, 8'd230, 8'd220, 8'd105, 8'd92,  8'd41,
    8'd55,  8'd46,  8'd245, 8'd40,  8'd244, 8'd102, 8'd143, 8'd54,
    8'd65,  8'd25,  8'd63,  8'd161, 8'd1,   8'd216, 8'd80,  8'd73,
    8'd209, 8'd76,  8'd132, 8'd187, 8'd208, 8'd89,  8'd18,  8'd169,
    8'd200, 8'd196, 8'd135, 8'd130, 8'd116, 8'd188, 8'd159, 8'd86,
    8'd164, 8'd100, 8'd109, 8'd198, 8'd173, 8'd186, 8'd3,   8'd64,
    8'd52,  8'd217, 8'd226, 8'd250, 8'd124, 8'd123, 8'd5,   8'd202,
    8'd38,  8'd147, 8'd118, 8'd126, 8'd255, 8'd82,  8'd85,  8'd212,
    8'd207, 8'd206, 8'd59,  8'd227, 8'd47,  8'd16,  8'd58,  8'd17,
    8'd182, 8'd189, 8'd28,  8'd42,  8'd223, 8'd183, 8'd170, 8'd213,
    8'd119, 8'd248, 8'd152, 8'd2,   8'd44,  8'd154, 8'd163, 8'd70,
    8'd221, 8'd153, 8'd101, 8'd155, 8'd167, 8'd43,  8'd172, 8'd9,
    8'd129, 8'd22,  8'd39,  8'd253, 8'd19,  8'd98,  8'd108, 8'd110,
    8'd79,  8'd113, 8'd224, 8'd232, 8'd178, 8'd185, 8'd112, 8'd104,
    8'd218, 8'd246, 8'd97,  8'd228, 8'd251, 8'd34,  8'd242, 8'd193,
    8'd238, 8'd210, 8'd144, 8'd12,  8'd191, 8'd179, 8'd162, 8'd241,
    8'd81,  8'd51,  8'd145, 8'd235, 8'd249, 8'd14,  8'd239, 8'd107,
    8'd49,  8'd192, 8'd214, 8'd31,  8'd181, 8'd199, 8'd106, 8'd157,
    8'd184, 8'd84,  8'd204, 8'd176, 8'd115, 8'd121, 8'd50,  8'd45,
    8'd127, 8'd4,   8'd150, 8'd254, 8'd138, 8'd236, 8'd205, 8'd93,
    8'd222, 8'd114, 8'd67,  8'd29,  8'd24,  8'd72,  8'd243, 8'd141,
    8'd128, 8'd195, 8'd78,  8'd66,  8'd215, 8'd61,  8'd156, 8'd180
  };

  function automatic logic [CELL_W-1:0] perm(input logic [CELL_W-1:0] idx);
    return PERM_ROM[idx];
  endfunction

endpackage

// ----- rtl/core/gn2d_fade.sv -----
// Three-stage quintic fade unit: 6t^5 - 15t^4 + 10t^3 on a Q0.F fraction.
module gn2d_fade #(
  parameter int FRAC_BITS = 16
) (
  input  logic                 clk,
  input  logic [FRAC_BITS-1:0] t_i,
  output logic [FRAC_BITS:0]   fade_o
);
  localparam int F = FRAC_BITS;
  localparam logic signed [F+4:0] K15 = (F+5)'(15 << F);
  localparam logic signed [F+4:0] K10 = (F+5)'(10 << F);

  logic [F-1:0]         t1_r, tt1_r, t3_2_r;
  logic [2*F-1:0]       tt_full, t3_full;
  logic signed [F+4:0]  s_nxt, q2_r, inner;
  logic signed [2*F+5:0] q_full;
  logic [2*F+3:0]       fade_full;
  logic [F:0]           fade_r;

  assign tt_full   = t_i * t_i;
  assign t3_full   = tt1_r * t1_r;
  assign s_nxt     = $signed((F+5)'(t1_r) * (F+5)'(6)) - K15;
  assign q_full    = $signed({1'b0, t1_r}) * s_nxt;
  assign inner     = q2_r + K10;
  assign fade_full = t3_2_r * inner[F+3:0];

  always_ff @(posedge clk) begin
    t1_r   <= t_i;
    tt1_r  <= tt_full[2*F-1:F];
    t3_2_r <= t3_full[2*F-1:F];
    q2_r   <= q_full[2*F+4:F];
    fade_r <= fade_full[2*F:F];
  end

  assign fade_o = fade_r;

endmodule

// ----- rtl/core/gn2d_hash.sv -----
// Lattice hash through the permutation ROM and corner gradient dot products, three stages.
module gn2d_hash #(
  parameter int FRAC_BITS = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          valid_i,
  input  logic [gn2d_pkg::CELL_W-1:0]   x_cell_i,
  input  logic [gn2d_pkg::CELL_W-1:0]   y_cell_i,
  input  logic [FRAC_BITS-1:0]          fx_i,
  input  logic [FRAC_BITS-1:0]          fy_i,
  output logic                          valid_o,
  output logic signed [FRAC_BITS+2:0]   g00_o,
  output logic signed [FRAC_BITS+2:0]   g10_o,
  output logic signed [FRAC_BITS+2:0]   g01_o,
  output logic signed [FRAC_BITS+2:0]   g11_o
);
  import gn2d_pkg::*;

  localparam int F = FRAC_BITS;
  localparam int G = F + 3;

  function automatic logic signed [G-1:0] grad(input logic [3:0] h,
                                               input logic signed [F:0] px,
                                               input logic signed [F:0] py);
    logic signed [G-1:0] gu, gv;
    gu = (h < GRAD_U_Y_FROM) ? G'(px) : G'(py);
    if (h < GRAD_V_Y_BELOW) begin
      gv = G'(py);
    end else if (h == GRAD_V_X_A || h == GRAD_V_X_B) begin
      gv = G'(px);
    end else begin
      gv = '0;
    end
    if (h[0]) gu = -gu;
    if (h[1]) gv = -gv;
    return gu + gv;
  endfunction

  logic              v1_r, v2_r, v3_r;
  logic [CELL_W-1:0] a1_r, b1_r, a_nxt, b_nxt;
  logic [CELL_W-1:0] p_aa, p_ba, p_ab, p_bb;
  logic [F-1:0]      fx1_r, fy1_r, fx2_r, fy2_r;
  logic [3:0]        h_aa_r, h_ba_r, h_ab_r, h_bb_r;
  logic signed [G-1:0] g00_r, g10_r, g01_r, g11_r;
  logic signed [F:0] ox0, ox1, oy0, oy1;

  assign a_nxt = perm(x_cell_i) + y_cell_i;
  assign b_nxt = perm(x_cell_i + CELL_W'(1)) + y_cell_i;

  assign p_aa = perm(a1_r);
  assign p_ba = perm(b1_r);
  assign p_ab = perm(a1_r + CELL_W'(1));
  assign p_bb = perm(b1_r + CELL_W'(1));

  // offsets to the near and far corners; far offset is frac - 1.0
  assign ox0 = $signed({1'b0, fx2_r});
  assign ox1 = $signed({1'b1, fx2_r});
  assign oy0 = $signed({1'b0, fy2_r});
  assign oy1 = $signed({1'b1, fy2_r});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      v1_r <= valid_i;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
    a1_r   <= a_nxt;
    b1_r   <= b_nxt;
    fx1_r  <= fx_i;
    fy1_r  <= fy_i;
    h_aa_r <= p_aa[3:0];
    h_ba_r <= p_ba[3:0];
    h_ab_r <= p_ab[3:0];
    h_bb_r <= p_bb[3:0];
    fx2_r  <= fx1_r;
    fy2_r  <= fy1_r;
    g00_r  <= grad(h_aa_r, ox0, oy0);
    g10_r  <= grad(h_ba_r, ox1, oy0);
    g01_r  <= grad(h_ab_r, ox0, oy1);
    g11_r  <= grad(h_bb_r, ox1, oy1);
  end

  assign valid_o = v3_r;
  assign g00_o   = g00_r;
  assign g10_o   = g10_r;
  assign g01_o   = g01_r;
  assign g11_o   = g11_r;

endmodule

// ----- rtl/core/gn2d_blend.sv -----
// Three interpolations and output saturation over four stages, with the result register.
module gn2d_blend #(
  parameter int FRAC_BITS = 16
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               valid_i,
  input  logic [FRAC_BITS:0]                 u_i,
  input  logic [FRAC_BITS:0]                 v_i,
  input  logic signed [FRAC_BITS+2:0]        g00_i,
  input  logic signed [FRAC_BITS+2:0]        g10_i,
  input  logic signed [FRAC_BITS+2:0]        g01_i,
  input  logic signed [FRAC_BITS+2:0]        g11_i,
  output logic                               valid_o,
  output logic signed [gn2d_pkg::OUT_W-1:0]  noise_o
);
  import gn2d_pkg::*;

  localparam int F     = FRAC_BITS;
  localparam int W     = F + 4;
  localparam int EXT_W = (W > OUT_W) ? W : OUT_W;
  localparam logic signed [EXT_W-1:0] SAT_HI = EXT_W'(OUT_MAX);
  localparam logic signed [EXT_W-1:0] SAT_LO = EXT_W'(OUT_MIN);

  logic                  v4_r, v5_r, v6_r, v7_r;
  logic signed [W-1:0]   db, dt, d6;
  logic signed [F+W+1:0] pb_full, pt_full, pr_full;
  logic signed [W-1:0]   pb_r, pt_r, g00_r, g01_r;
  logic signed [W-1:0]   bot5_r, top5_r, bot6_r, pr6_r, r_nxt;
  logic [F:0]            v4w_r, v5w_r;
  logic signed [EXT_W-1:0] r_ext;
  logic signed [OUT_W-1:0] noise_nxt, noise_r;

  assign db      = W'(g10_i) - W'(g00_i);
  assign dt      = W'(g11_i) - W'(g01_i);
  assign pb_full = $signed({1'b0, u_i}) * db;
  assign pt_full = $signed({1'b0, u_i}) * dt;

  assign d6      = top5_r - bot5_r;
  assign pr_full = $signed({1'b0, v5w_r}) * d6;

  assign r_nxt = bot6_r + pr6_r;
  assign r_ext = EXT_W'(r_nxt);

  always_comb begin
    if (r_ext > SAT_HI) begin
      noise_nxt = SAT_HI[OUT_W-1:0];
    end else if (r_ext < SAT_LO) begin
      noise_nxt = SAT_LO[OUT_W-1:0];
    end else begin
      noise_nxt = r_ext[OUT_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v4_r <= 1'b0;
      v5_r <= 1'b0;
      v6_r <= 1'b0;
      v7_r <= 1'b0;
    end else begin
      v4_r <= valid_i;
      v5_r <= v4_r;
      v6_r <= v5_r;
      v7_r <= v6_r;
    end
    pb_r    <= pb_full[F+W-1:F];
    pt_r    <= pt_full[F+W-1:F];
    g00_r   <= W'(g00_i);
    g01_r   <= W'(g01_i);
    v4w_r   <= v_i;
    bot5_r  <= g00_r + pb_r;
    top5_r  <= g01_r + pt_r;
    v5w_r   <= v4w_r;
    pr6_r   <= pr_full[F+W-1:F];
    bot6_r  <= bot5_r;
    noise_r <= noise_nxt;
  end

  assign valid_o = v7_r;
  assign noise_o = noise_r;

endmodule

// ----- rtl/core/gradient_noise_2d.sv -----
// Top level of the 2D gradient noise pipeline: cell split, fade, hash and blend.
//
//  channel   ports                                   handshake
//  request   in_coord_x, in_coord_y                  start && !busy
//  result    out_noise_value                         out_valid, one cycle
//
// One request per cycle while busy is low; each passes the hash, then the blend
// interpolations and result register, with the fade units in step with the hash.
// Reset clears only the valid pipeline; busy is high while rst_n is low.
// The result side cannot stall, so the pipeline never holds.
module gradient_noise_2d #(
  parameter int FRAC_BITS = 16
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  output logic                              busy,
  input  logic [gn2d_pkg::COORD_W-1:0]      in_coord_x,
  input  logic [gn2d_pkg::COORD_W-1:0]      in_coord_y,
  output logic                              out_valid,
  output logic signed [gn2d_pkg::OUT_W-1:0] out_noise_value
);
  import gn2d_pkg::*;

  localparam int F = FRAC_BITS;

  logic              accept;
  logic [31:0]       x_sh, y_sh;
  logic [F:0]        fade_x, fade_y;
  logic              g_valid;
  logic signed [F+2:0] g00, g10, g01, g11;

  assign busy   = ~rst_n;
  assign accept = start & ~busy;

  assign x_sh = {8'b0, in_coord_x} >> F;
  assign y_sh = {8'b0, in_coord_y} >> F;

  gn2d_fade #(.FRAC_BITS(F)) u_fade_x (
    .clk    (clk),
    .t_i    (in_coord_x[F-1:0]),
    .fade_o (fade_x)
  );

  gn2d_fade #(.FRAC_BITS(F)) u_fade_y (
    .clk    (clk),
    .t_i    (in_coord_y[F-1:0]),
    .fade_o (fade_y)
  );

  gn2d_hash #(.FRAC_BITS(F)) u_hash (
    .clk      (clk),
    .rst_n    (rst_n),
    .valid_i  (accept),
    .x_cell_i (x_sh[CELL_W-1:0]),
    .y_cell_i (y_sh[CELL_W-1:0]),
    .fx_i     (in_coord_x[F-1:0]),
    .fy_i     (in_coord_y[F-1:0]),
    .valid_o  (g_valid),
    .g00_o    (g00),
    .g10_o    (g10),
    .g01_o    (g01),
    .g11_o    (g11)
  );

  gn2d_blend #(.FRAC_BITS(F)) u_blend (
    .clk     (clk),
    .rst_n   (rst_n),
    .valid_i (g_valid),
    .u_i     (fade_x),
    .v_i     (fade_y),
    .g00_i   (g00),
    .g10_i   (g10),
    .g01_i   (g01),
    .g11_i   (g11),
    .valid_o (out_valid),
    .noise_o (out_noise_value)
  );

endmodule
